FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int DATA_W = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NULL    = 2'd2,
        ST_BADPTR  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_APPEND,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;

    // Register indexes on the configuration port.
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

endpackage

FILE: hw/rtl/ffha_table.sv
// Block table memory: payload size and used flag for each block, one write port
// and one registered read port.
module ffha_table #(
    parameter int MAX_BLOCKS = 64,
    parameter int IDX_W      = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [31:0]           wr_size,
    input  logic                  wr_used,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [31:0]           rd_size,
    output logic                  rd_used
);
    logic [32:0] mem [MAX_BLOCKS];
    logic [32:0] rd_data_reg;

    // Write and registered read share one clocked block.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {wr_used, wr_size};
        end
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_size = rd_data_reg[31:0];
    assign rd_used = rd_data_reg[32];
endmodule

FILE: hw/rtl/first_fit_heap_allocator_core.sv
// An allocate walks the table entries in order from block 0 and appends at the break if
// none fits; a free walks to its block, then runs a merge pass that moves entries down.
// One request at a time: s_tready stays low until the response is taken. A free merges
// every adjacent pair of free blocks in the table, and all walks go through the one
// table port. Reset: synchronous active-low aresetn clears the state, the heap base and
// limit registers, the block count and break state; the table memory is not cleared
// since only live entries are read.
module first_fit_heap_allocator_core #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_size[31:0], block_address[63:32]
    input  logic        s_tuser,   // kind: 0 allocate, 1 free
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_address[31:0], status[33:32], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffha_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);

    state_t state_reg, state_next;

    logic [31:0] heap_base_reg, heap_limit_reg;
    logic [31:0] heap_start_reg, brk_reg;
    logic        brk_started_reg;
    logic [CNT_W-1:0] count_reg;
    logic [32:0] rounded_reg;
    logic [31:0] ptr_reg;
    logic [CNT_W-1:0] k_reg, j_reg;
    logic [31:0] addr_reg, acc_reg;
    logic        acc_free_reg;
    logic [31:0] out_addr_reg;
    status_t     out_status_reg;

    logic        wr_en;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic [31:0] wr_size, rd_size;
    logic        wr_used, rd_used;

    ffha_table #(.MAX_BLOCKS(MAX_BLOCKS), .IDX_W(IDX_W)) u_table (
        .aclk(aclk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_size(wr_size),
        .wr_used(wr_used), .rd_idx(rd_idx), .rd_size(rd_size), .rd_used(rd_used)
    );

    // Shared adder: next block address from the current one.
    logic [31:0] addr_step;
    assign addr_step = addr_reg + 32'(HEADER_BYTES) + rd_size;

    // Append arithmetic on the latched rounded size.
    logic [31:0] brk_now;
    logic [33:0] total, next_brk;
    assign brk_now  = brk_started_reg ? brk_reg : heap_base_reg;
    assign total    = (HDR + {1'b0, rounded_reg} + 34'd15) & ~34'd15;
    assign next_brk = {2'b0, brk_now} + total;

    logic s_fire, m_fire, cfg_wr;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, out_status_reg, out_addr_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HEAP_LIMIT) ? heap_limit_reg : heap_base_reg;

    // The shift after a merge starts if block k+2 lies below the old count, and runs while j+1 is below the count.
    logic k_live, k1_live, k2_live, j1_live;
    assign k_live  = (k_reg < count_reg);
    assign k1_live = ((k_reg + 1'b1) < count_reg);
    assign k2_live = ((k_reg + 2'd2) < count_reg);
    assign j1_live = ((j_reg + 1'b1) < count_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser) begin
                        state_next = (s_tdata[63:32] == 32'd0) ? S_OUT : S_FREE_RD;
                    end else if (s_tdata[31:0] == 32'd0) begin
                        state_next = S_OUT;
                    end else if (s_tdata[31:4] == 28'hFFFFFFF && s_tdata[3:0] != 4'd0) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_ALLOC_RD;
                    end
                end
            end
            S_ALLOC_RD:  state_next = k_live ? S_ALLOC_CHK : S_APPEND;
            S_ALLOC_CHK: state_next = (!rd_used && {1'b0, rd_size} >= rounded_reg) ?
                                      S_OUT : S_ALLOC_RD;
            S_APPEND:    state_next = S_OUT;
            S_FREE_RD:   state_next = k_live ? S_FREE_CHK : S_OUT;
            S_FREE_CHK:  state_next = (addr_reg + 32'(HEADER_BYTES) == ptr_reg) ?
                                      S_MERGE_RD : S_FREE_RD;
            S_MERGE_RD:  state_next = k1_live ? S_MERGE_CHK : S_OUT;
            S_MERGE_CHK: state_next = (acc_free_reg && !rd_used) ?
                                      (k2_live ? S_SHIFT_RD : S_MERGE_RD) : S_MERGE_RD;
            S_SHIFT_RD:  state_next = S_SHIFT_WR;
            S_SHIFT_WR:  state_next = j1_live ? S_SHIFT_RD : S_MERGE_RD;
            S_OUT:       state_next = m_fire ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Table port control.
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = k_reg[IDX_W-1:0];
        wr_size = acc_reg;
        wr_used = 1'b0;
        rd_idx  = k_reg[IDX_W-1:0];
        unique case (state_reg)
            S_ALLOC_CHK: begin
                if (!rd_used && {1'b0, rd_size} >= rounded_reg) begin
                    wr_en = 1'b1; wr_size = rd_size; wr_used = 1'b1;
                end
            end
            S_APPEND: begin
                wr_idx  = count_reg[IDX_W-1:0];
                wr_size = 32'(total - HDR);
                wr_used = 1'b1;
                wr_en   = (count_reg < MAX_CNT) && (next_brk <= {2'b0, heap_limit_reg});
            end
            S_FREE_CHK: begin
                if (addr_reg + 32'(HEADER_BYTES) == ptr_reg) begin
                    wr_en = 1'b1; wr_size = rd_size; wr_used = 1'b0;
                end
            end
            S_MERGE_RD:  rd_idx = IDX_W'(k_reg + 1'b1);
            S_MERGE_CHK: begin
                wr_size = acc_reg + 32'(HEADER_BYTES) + rd_size;
                wr_used = 1'b0;
                wr_en   = acc_free_reg && !rd_used;
            end
            S_SHIFT_RD:  rd_idx = IDX_W'(j_reg + 1'b1);
            S_SHIFT_WR: begin
                wr_en = 1'b1; wr_idx = j_reg[IDX_W-1:0];
                wr_size = rd_size; wr_used = rd_used;
            end
            default: ;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            heap_base_reg <= '0; heap_limit_reg <= '0;
            brk_started_reg <= 1'b0; count_reg <= '0;
            brk_reg <= '0; heap_start_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2] == REG_HEAP_BASE) heap_base_reg <= pwdata;
                else heap_limit_reg <= pwdata;
            end
            unique case (state_reg)
                S_IDLE: if (s_fire) begin
                    ptr_reg  <= s_tdata[63:32];
                    rounded_reg <= ({1'b0, s_tdata[31:0]} + 33'd15) & ~33'd15;
                    k_reg <= '0;
                    addr_reg <= heap_start_reg;
                    out_addr_reg <= '0;
                    out_status_reg <= (s_tuser ? (s_tdata[63:32] == 32'd0)
                                               : (s_tdata[31:0] == 32'd0)) ? ST_NULL
                                    : (s_tuser ? ST_BADPTR : ST_NOSPACE);
                end
                S_ALLOC_CHK: begin
                    if (!rd_used && {1'b0, rd_size} >= rounded_reg) begin
                        out_addr_reg <= addr_reg + 32'(HEADER_BYTES);
                        out_status_reg <= ST_DONE;
                    end else begin
                        addr_reg <= addr_step;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_APPEND: begin
                    if (!brk_started_reg) begin
                        brk_started_reg <= 1'b1;
                        heap_start_reg <= heap_base_reg;
                    end
                    brk_reg <= brk_now;
                    if (wr_en) begin
                        brk_reg <= next_brk[31:0];
                        count_reg <= count_reg + 1'b1;
                        out_addr_reg <= brk_now + 32'(HEADER_BYTES);
                        out_status_reg <= ST_DONE;
                    end
                end
                S_FREE_CHK: begin
                    if (addr_reg + 32'(HEADER_BYTES) == ptr_reg) begin
                        out_status_reg <= ST_DONE;
                        acc_reg <= '0;
                        acc_free_reg <= 1'b0;
                        // Prime merge walk: block 0 read next as the "k+1" of a dummy.
                        k_reg <= '1;
                    end else begin
                        addr_reg <= addr_step;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_MERGE_CHK: begin
                    if (acc_free_reg && !rd_used) begin
                        acc_reg <= wr_size;
                        count_reg <= count_reg - 1'b1;
                        j_reg <= k_reg + 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        acc_reg <= rd_size;
                        acc_free_reg <= !rd_used;
                    end
                end
                S_SHIFT_WR: j_reg <= j_reg + 1'b1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The block count never exceeds the table depth.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT) else $error("block count overflow");
    // A failed or ignored request always carries a zero address.
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] != ST_DONE) |-> (m_tdata[31:0] == 32'd0))
        else $error("failed request carries an address");
    // The count only grows in the append state.
    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > $past(count_reg)) |-> ($past(state_reg) == S_APPEND))
        else $error("unexpected block count growth");
`endif
endmodule
